### sv/tcqla_pkg.sv
// ----------------------------------------------------------------------------
// tcqla_pkg
// Shared types and constants for the two-class quota lock arbiter.
// ----------------------------------------------------------------------------
`default_nettype none

package tcqla_pkg;

  // Field widths fixed by the item format
  localparam int unsigned REQ_ID_W = 8;
  localparam int unsigned QUOTA_W  = 4;
  localparam int unsigned STATUS_W = 3;

  // Foreground quota after reset
  localparam logic [QUOTA_W-1:0] QUOTA_RESET = 4'd3;

  typedef logic [REQ_ID_W-1:0] req_id_t;
  typedef logic [QUOTA_W-1:0]  quota_t;

  // Operation codes
  typedef enum logic {
    OP_LOCK    = 1'b0,
    OP_RELEASE = 1'b1
  } op_t;

  // Result status codes
  typedef enum logic [STATUS_W-1:0] {
    ST_GRANTED      = 3'd0,
    ST_QUEUED       = 3'd1,
    ST_QUEUE_FULL   = 3'd2,
    ST_OWNER_RELOCK = 3'd3,
    ST_RELEASE_FREE = 3'd4
  } status_t;

  // Wait queue status toward the arbiter core
  typedef struct packed {
    logic empty;
    logic full;
  } q_stat_t;

endpackage

`default_nettype wire

### sv/tcqla_if.sv
// ----------------------------------------------------------------------------
// tcqla interfaces
// Request, response and quota configuration channels (valid/ready).
// ----------------------------------------------------------------------------
`default_nettype none

interface tcqla_req_if;
  logic                     valid;
  logic                     ready;
  tcqla_pkg::op_t           op;
  tcqla_pkg::req_id_t       requester_id;
  logic                     is_background;

  modport source (output valid, op, requester_id, is_background, input ready);
  modport sink   (input valid, op, requester_id, is_background, output ready);
endinterface

interface tcqla_rsp_if;
  logic                     valid;
  logic                     ready;
  tcqla_pkg::status_t       status;
  logic                     grant_valid;
  tcqla_pkg::req_id_t       grant_id;
  logic                     lock_held;

  modport source (output valid, status, grant_valid, grant_id, lock_held, input ready);
  modport sink   (input valid, status, grant_valid, grant_id, lock_held, output ready);
endinterface

interface tcqla_cfg_if;
  logic                     valid;
  logic                     ready;
  tcqla_pkg::quota_t        foreground_quota;

  modport source (output valid, foreground_quota, input ready);
  modport sink   (input valid, foreground_quota, output ready);
endinterface

`default_nettype wire

### sv/tcqla_ram.sv
// ----------------------------------------------------------------------------
// tcqla_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module tcqla_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  wire logic                                        clk,
  input  wire logic                                        wr_en,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
  input  wire logic [WIDTH-1:0]                            wr_data,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
  output      logic [WIDTH-1:0]                            rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port and registered read port (read returns old data on collision)
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

`default_nettype wire

### sv/tcqla_queue.sv
// ----------------------------------------------------------------------------
// tcqla_queue
// Circular wait queue on a RAM; the head entry is prefetched every cycle
// so that its data is ready at head_data whenever a pop comes.
// ----------------------------------------------------------------------------
`default_nettype none

module tcqla_queue #(
  parameter int unsigned DEPTH = 16,
  parameter int unsigned ID_W  = 8
) (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            push,
  input  wire logic [ID_W-1:0] push_data,
  input  wire logic            pop,
  output      logic [ID_W-1:0] head_data,
  output      tcqla_pkg::q_stat_t stat
);
  import tcqla_pkg::*;

  localparam int unsigned PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CntW = $clog2(DEPTH + 1);
  localparam int unsigned SumW = PtrW + 1;
  localparam logic [SumW-1:0] DepthS = SumW'(DEPTH);
  localparam logic [PtrW-1:0] LastPtr = PtrW'(DEPTH - 1);
  localparam logic [CntW-1:0] DepthC = CntW'(DEPTH);

  logic [PtrW-1:0] head;
  logic [PtrW-1:0] head_next;
  logic [CntW-1:0] count;
  logic [CntW-1:0] count_next;
  logic [SumW-1:0] tail_sum;
  logic [PtrW-1:0] tail;
  logic [PtrW-1:0] rd_addr;
  logic [ID_W-1:0] rd_data;
  logic            byp_hit;
  logic [ID_W-1:0] byp_data;

  // Tail slot: head plus count, wrapped once
  always_comb begin
    tail_sum = {1'b0, head} + SumW'(count);
    if (tail_sum >= DepthS) begin
      tail = PtrW'(tail_sum - DepthS);
    end else begin
      tail = PtrW'(tail_sum);
    end
  end

  // Advance head and occupancy
  always_comb begin
    head_next = head;
    if (pop) begin
      head_next = (head == LastPtr) ? '0 : head + PtrW'(1);
    end
    count_next = count;
    if (push && !pop) begin
      count_next = count + CntW'(1);
    end else if (pop && !push) begin
      count_next = count - CntW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      head    <= '0;
      count   <= '0;
      byp_hit <= 1'b0;
    end else begin
      head    <= head_next;
      count   <= count_next;
      byp_hit <= push && (tail == rd_addr);
    end
    byp_data <= push_data;
  end

  // Prefetch the next head; forward a write that lands on it
  assign rd_addr   = rst ? '0 : head_next;
  assign head_data = byp_hit ? byp_data : rd_data;

  assign stat.empty = (count == '0);
  assign stat.full  = (count == DepthC);

  tcqla_ram #(
    .WIDTH (ID_W),
    .DEPTH (DEPTH)
  ) u_ram (
    .clk     (clk),
    .wr_en   (push),
    .wr_addr (tail),
    .wr_data (push_data),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

endmodule

`default_nettype wire

### sv/two_class_quota_lock_arbiter_unit.sv
// ----------------------------------------------------------------------------
// two_class_quota_lock_arbiter_unit
// A result is registered and valid in the cycle after its request is transferred.
// Throughput: one request or release per cycle while no result is stalled, set
// by the single decision stage between the request port and result register.
// Reset (rst, synchronous): lock free, both queues empty, quota 3.
// ----------------------------------------------------------------------------
`default_nettype none

module two_class_quota_lock_arbiter_unit #(
  parameter int unsigned QUEUE_DEPTH = 16,
  parameter int unsigned ID_WIDTH    = 8
) (
  input wire logic  clk,
  input wire logic  rst,
  tcqla_req_if.sink   req,
  tcqla_rsp_if.source rsp,
  tcqla_cfg_if.sink   cfg
);
  import tcqla_pkg::*;

  typedef logic [ID_WIDTH-1:0] id_t;

  logic      accept;
  id_t       req_id;
  quota_t    fore_quota;
  id_t       owner_id;
  id_t       owner_id_next;
  logic      owner_present;
  logic      owner_present_next;
  quota_t    quota_left;
  quota_t    quota_left_next;
  logic      fq_push;
  logic      fq_pop;
  logic      bq_push;
  logic      bq_pop;
  id_t       fq_head;
  id_t       bq_head;
  q_stat_t   fq_stat;
  q_stat_t   bq_stat;
  status_t   status_next;
  logic      grant_next;
  id_t       grant_id_next;
  logic      out_valid;

  // Take a new request whenever the result register is free or draining
  assign req.ready = !out_valid || rsp.ready;
  assign accept    = req.valid && req.ready;
  assign req_id    = ID_WIDTH'(req.requester_id);
  assign cfg.ready = 1'b1;

  // Arbitration decision for the current request
  always_comb begin
    owner_id_next      = owner_id;
    owner_present_next = owner_present;
    quota_left_next    = quota_left;
    fq_push            = 1'b0;
    fq_pop             = 1'b0;
    bq_push            = 1'b0;
    bq_pop             = 1'b0;
    status_next        = ST_GRANTED;
    grant_next         = 1'b0;
    grant_id_next      = '0;
    unique case (req.op)
      OP_LOCK: begin
        if (!owner_present) begin
          owner_present_next = 1'b1;
          owner_id_next      = req_id;
          grant_next         = 1'b1;
          grant_id_next      = req_id;
        end else if (owner_id == req_id) begin
          status_next = ST_OWNER_RELOCK;
        end else if (req.is_background) begin
          if (bq_stat.full) begin
            status_next = ST_QUEUE_FULL;
          end else begin
            bq_push     = accept;
            status_next = ST_QUEUED;
          end
        end else begin
          if (fq_stat.full) begin
            status_next = ST_QUEUE_FULL;
          end else begin
            fq_push     = accept;
            status_next = ST_QUEUED;
          end
        end
      end
      OP_RELEASE: begin
        if (!owner_present) begin
          status_next = ST_RELEASE_FREE;
        end else if (!fq_stat.empty && (quota_left != '0 || bq_stat.empty)) begin
          if (quota_left != '0) begin
            quota_left_next = quota_left - QUOTA_W'(1);
          end
          fq_pop        = accept;
          owner_id_next = fq_head;
          grant_next    = 1'b1;
          grant_id_next = fq_head;
        end else if (!bq_stat.empty) begin
          quota_left_next = fore_quota;
          bq_pop          = accept;
          owner_id_next   = bq_head;
          grant_next      = 1'b1;
          grant_id_next   = bq_head;
        end else begin
          owner_present_next = 1'b0;
        end
      end
      default: begin
        status_next = ST_GRANTED;
      end
    endcase
  end

  // Lock state, quota register and result register
  always_ff @(posedge clk) begin
    if (rst) begin
      owner_id      <= '0;
      owner_present <= 1'b0;
      quota_left    <= QUOTA_RESET;
      fore_quota    <= QUOTA_RESET;
      out_valid     <= 1'b0;
    end else begin
      if (cfg.valid && cfg.ready) begin
        fore_quota <= cfg.foreground_quota;
      end
      if (accept) begin
        owner_id      <= owner_id_next;
        owner_present <= owner_present_next;
        quota_left    <= quota_left_next;
        out_valid     <= 1'b1;
      end else if (rsp.ready) begin
        out_valid <= 1'b0;
      end
    end
    if (accept) begin
      rsp.status      <= status_next;
      rsp.grant_valid <= grant_next;
      rsp.grant_id    <= REQ_ID_W'(grant_id_next);
      rsp.lock_held   <= owner_present_next;
    end
  end

  assign rsp.valid = out_valid;

  tcqla_queue #(
    .DEPTH (QUEUE_DEPTH),
    .ID_W  (ID_WIDTH)
  ) u_fore_q (
    .clk       (clk),
    .rst       (rst),
    .push      (fq_push),
    .push_data (req_id),
    .pop       (fq_pop),
    .head_data (fq_head),
    .stat      (fq_stat)
  );

  tcqla_queue #(
    .DEPTH (QUEUE_DEPTH),
    .ID_W  (ID_WIDTH)
  ) u_back_q (
    .clk       (clk),
    .rst       (rst),
    .push      (bq_push),
    .push_data (req_id),
    .pop       (bq_pop),
    .head_data (bq_head),
    .stat      (bq_stat)
  );

endmodule

`default_nettype wire

### sv/tcqla_checker.sv
// ----------------------------------------------------------------------------
// tcqla_checker
// Port-level checks for the lock arbiter, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module tcqla_checker (
  input wire logic                clk,
  input wire logic                rst,
  input wire logic                req_valid,
  input wire logic                req_ready,
  input wire logic                rsp_valid,
  input wire logic                rsp_ready,
  input wire tcqla_pkg::status_t  rsp_status,
  input wire logic                rsp_grant_valid,
  input wire tcqla_pkg::req_id_t  rsp_grant_id,
  input wire logic                rsp_lock_held
);
  import tcqla_pkg::*;

  // Every transferred request yields a result in the next cycle
  a_req_to_rsp: assert property (@(posedge clk) disable iff (rst)
    req_valid && req_ready |=> rsp_valid)
    else $error("request transfer without a result in the next cycle");

  // A stalled result holds its payload
  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_status) &&
      $stable(rsp_grant_valid) && $stable(rsp_grant_id) && $stable(rsp_lock_held))
    else $error("stalled result changed");

  // A grant always leaves the lock held and reports success
  a_grant_held: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp_grant_valid |-> rsp_lock_held && rsp_status == ST_GRANTED)
    else $error("grant without lock held");

  // Refused or queued requests keep the lock owned and grant nothing
  a_refuse_held: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && (rsp_status == ST_QUEUED || rsp_status == ST_QUEUE_FULL ||
      rsp_status == ST_OWNER_RELOCK) |-> rsp_lock_held && !rsp_grant_valid)
    else $error("queued or refused request with wrong lock state");

  // Release while free leaves the lock free and grants nothing
  a_release_free: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp_status == ST_RELEASE_FREE |->
      !rsp_lock_held && !rsp_grant_valid && rsp_grant_id == '0)
    else $error("release while free reported wrong result");

endmodule

bind two_class_quota_lock_arbiter_unit tcqla_checker u_tcqla_checker (
  .clk             (clk),
  .rst             (rst),
  .req_valid       (req.valid),
  .req_ready       (req.ready),
  .rsp_valid       (rsp.valid),
  .rsp_ready       (rsp.ready),
  .rsp_status      (rsp.status),
  .rsp_grant_valid (rsp.grant_valid),
  .rsp_grant_id    (rsp.grant_id),
  .rsp_lock_held   (rsp.lock_held)
);

`default_nettype wire

### test/tb_two_class_quota_lock_arbiter_unit.sv
// ----------------------------------------------------------------------------
// tb_two_class_quota_lock_arbiter_unit
// Self-checking bench for the two-class quota lock arbiter. A shadow arbiter
// tracks the owner, both wait queues and the quota, and predicts one outcome
// per request transfer. Every response transfer is checked against the oldest
// prediction. Directed sequences cover the special cases, then random
// traffic runs under several idle/stall mixes and quota settings.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_two_class_quota_lock_arbiter_unit;
  timeunit 1ns;
  timeprecision 1ps;

  import tcqla_pkg::*;

  localparam int unsigned WAIT_DEPTH  = 16;
  localparam int unsigned STALL_LIMIT = 2000;
  localparam int unsigned MAX_REPORTS = 10;
  localparam int unsigned PHASE_ITEMS = 220;

  typedef struct packed {
    status_t status;
    logic    grant_valid;
    req_id_t grant_id;
    logic    lock_held;
  } outcome_t;

  logic clk;
  logic rst;

  tcqla_req_if req_ch ();
  tcqla_rsp_if rsp_ch ();
  tcqla_cfg_if cfg_ch ();

  two_class_quota_lock_arbiter_unit u_dut (
    .clk (clk),
    .rst (rst),
    .req (req_ch),
    .rsp (rsp_ch),
    .cfg (cfg_ch)
  );

  // Shadow arbiter state
  req_id_t     holder_id;
  logic        holder_valid;
  req_id_t     fore_waiting[$];
  req_id_t     back_waiting[$];
  quota_t      quota_left;
  quota_t      quota_setting;

  outcome_t    pending_outcomes[$];
  int unsigned mismatch_count;
  int unsigned items_sent;
  int unsigned idle_cycles;
  int unsigned send_idle_pct;
  int unsigned recv_stall_pct;

  // Free-running clock
  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // Decide one request or release and advance the shadow state
  function automatic outcome_t arbitrate(op_t op, req_id_t id, logic bg);
    outcome_t res;
    res = '{status: ST_GRANTED, grant_valid: 1'b0, grant_id: '0, lock_held: 1'b0};
    if (op == OP_LOCK) begin
      if (!holder_valid) begin
        holder_valid    = 1'b1;
        holder_id       = id;
        res.grant_valid = 1'b1;
        res.grant_id    = id;
      end else if (holder_id == id) begin
        res.status = ST_OWNER_RELOCK;
      end else if (bg) begin
        if (back_waiting.size() < WAIT_DEPTH) begin
          back_waiting.push_back(id);
          res.status = ST_QUEUED;
        end else begin
          res.status = ST_QUEUE_FULL;
        end
      end else begin
        if (fore_waiting.size() < WAIT_DEPTH) begin
          fore_waiting.push_back(id);
          res.status = ST_QUEUED;
        end else begin
          res.status = ST_QUEUE_FULL;
        end
      end
    end else begin
      if (!holder_valid) begin
        res.status = ST_RELEASE_FREE;
      end else if (fore_waiting.size() != 0 &&
                   (quota_left != 0 || back_waiting.size() == 0)) begin
        if (quota_left != 0) quota_left = quota_left - quota_t'(1);
        holder_id       = fore_waiting.pop_front();
        res.grant_valid = 1'b1;
        res.grant_id    = holder_id;
      end else if (back_waiting.size() != 0) begin
        quota_left      = quota_setting;
        holder_id       = back_waiting.pop_front();
        res.grant_valid = 1'b1;
        res.grant_id    = holder_id;
      end else begin
        holder_valid = 1'b0;
      end
    end
    res.lock_held = holder_valid;
    return res;
  endfunction

  // Track transfers, predict, check and watch for a hang
  always @(posedge clk) begin
    outcome_t seen;
    outcome_t want;
    if (rst) begin
      holder_id     = '0;
      holder_valid  = 1'b0;
      quota_left    = QUOTA_RESET;
      quota_setting = QUOTA_RESET;
      fore_waiting.delete();
      back_waiting.delete();
      pending_outcomes.delete();
      idle_cycles   = 0;
    end else begin
      if (cfg_ch.valid && cfg_ch.ready) quota_setting = cfg_ch.foreground_quota;
      if (req_ch.valid && req_ch.ready)
        pending_outcomes.push_back(arbitrate(req_ch.op, req_ch.requester_id,
                                             req_ch.is_background));
      if (rsp_ch.valid && rsp_ch.ready) begin
        seen = '{status: rsp_ch.status, grant_valid: rsp_ch.grant_valid,
                 grant_id: rsp_ch.grant_id, lock_held: rsp_ch.lock_held};
        if (pending_outcomes.size() == 0) begin
          mismatch_count++;
          if (mismatch_count <= MAX_REPORTS)
            $display("%0t: unexpected result status=%0d grant=%0b id=%02h held=%0b",
                     $realtime, seen.status, seen.grant_valid, seen.grant_id, seen.lock_held);
        end else begin
          want = pending_outcomes.pop_front();
          if (seen !== want) begin
            mismatch_count++;
            if (mismatch_count <= MAX_REPORTS)
              $display("%0t: mismatch exp status=%0d grant=%0b id=%02h held=%0b",
                       $realtime, want.status, want.grant_valid, want.grant_id,
                       want.lock_held,
                       " / got status=%0d grant=%0b id=%02h held=%0b",
                       seen.status, seen.grant_valid, seen.grant_id, seen.lock_held);
          end
        end
      end
      if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready) ||
          (cfg_ch.valid && cfg_ch.ready)) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
        if (idle_cycles >= STALL_LIMIT) begin
          $display("TEST FAILED");
          $finish;
        end
      end
    end
  end

  // Stall the response channel at random
  always @(negedge clk) begin
    rsp_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
  end

  // Send one request; idle first at random, hold until the transfer
  task automatic send_request(op_t op, req_id_t id, logic bg);
    @(negedge clk);
    while ($urandom_range(99) < send_idle_pct) begin
      req_ch.valid = 1'b0;
      @(negedge clk);
    end
    req_ch.valid         = 1'b1;
    req_ch.op            = op;
    req_ch.requester_id  = id;
    req_ch.is_background = bg;
    @(posedge clk);
    while (!req_ch.ready) @(posedge clk);
    items_sent++;
  endtask

  // Drop valid and hold until every predicted result has arrived
  task automatic wait_drained();
    @(negedge clk);
    req_ch.valid = 1'b0;
    while (pending_outcomes.size() != 0) @(negedge clk);
  endtask

  // Write the quota register while the arbiter is idle
  task automatic write_quota(quota_t quota);
    wait_drained();
    repeat (2) @(negedge clk);
    cfg_ch.valid            = 1'b1;
    cfg_ch.foreground_quota = quota;
    @(posedge clk);
    while (!cfg_ch.ready) @(posedge clk);
    @(negedge clk);
    cfg_ch.valid = 1'b0;
  endtask

  // Release while free, grant, owner relock, release with no waiters
  task automatic test_free_lock();
    send_request(OP_RELEASE, 8'hFF, 1'b1);
    send_request(OP_LOCK, 8'h00, 1'b0);
    send_request(OP_LOCK, 8'h00, 1'b1);
    send_request(OP_RELEASE, 8'h00, 1'b0);
  endtask

  // Fill the foreground queue past full, then release through the quota
  task automatic test_queue_full();
    send_request(OP_LOCK, 8'hFF, 1'b1);
    for (int i = 0; i < WAIT_DEPTH; i++) send_request(OP_LOCK, req_id_t'(8'h10 + i), 1'b0);
    send_request(OP_LOCK, 8'hA5, 1'b0);
    send_request(OP_LOCK, 8'h5A, 1'b1);
    repeat (5) send_request(OP_RELEASE, 8'h33, 1'b0);
  endtask

  // Zero quota: background waiters win
  task automatic test_quota_zero();
    write_quota(4'd0);
    send_request(OP_LOCK, 8'h80, 1'b1);
    send_request(OP_LOCK, 8'h81, 1'b1);
    send_request(OP_LOCK, 8'h14, 1'b0);
    repeat (5) send_request(OP_RELEASE, 8'hC3, 1'b1);
  endtask

  // Full quota reload after a background grant
  task automatic test_quota_max();
    write_quota(4'd15);
    send_request(OP_LOCK, 8'h82, 1'b1);
    repeat (3) send_request(OP_RELEASE, 8'h00, 1'b0);
  endtask

  // Random traffic under one idle/stall mix and quota setting
  task automatic test_random_traffic(int unsigned idle_pct, int unsigned stall_pct,
                                     quota_t quota);
    int unsigned target;
    int unsigned pick;
    int unsigned id_pick;
    req_id_t     id;
    logic        bg;
    write_quota(quota);
    send_idle_pct  = idle_pct;
    recv_stall_pct = stall_pct;
    target = items_sent + PHASE_ITEMS;
    while (items_sent < target) begin
      pick = $urandom_range(99);
      bg   = 1'($urandom_range(1));
      if (pick < 3) begin
        // burst of requests of one class to reach a full queue
        repeat (WAIT_DEPTH + 2) send_request(OP_LOCK, req_id_t'($urandom_range(255)), bg);
      end else if (pick < 6) begin
        // burst of releases to drain down to a free lock
        repeat (WAIT_DEPTH + 2)
          send_request(OP_RELEASE, req_id_t'($urandom_range(255)), 1'($urandom_range(1)));
      end else if (pick < 52) begin
        if (pick < 8) wait_drained();
        send_request(OP_RELEASE, req_id_t'($urandom_range(255)), bg);
      end else begin
        id_pick = $urandom_range(9);
        if (id_pick == 0)     id = holder_id;
        else if (id_pick < 4) id = req_id_t'($urandom_range(7));
        else                  id = req_id_t'($urandom_range(255));
        send_request(OP_LOCK, id, bg);
      end
    end
  endtask

  initial begin
    rst                     = 1'b1;
    req_ch.valid            = 1'b0;
    req_ch.op               = OP_LOCK;
    req_ch.requester_id     = '0;
    req_ch.is_background    = 1'b0;
    rsp_ch.ready            = 1'b0;
    cfg_ch.valid            = 1'b0;
    cfg_ch.foreground_quota = '0;
    mismatch_count          = 0;
    items_sent              = 0;
    send_idle_pct           = 0;
    recv_stall_pct          = 0;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    test_free_lock();
    test_queue_full();
    test_quota_zero();
    test_quota_max();
    test_random_traffic(0, 0, 4'd1);
    test_random_traffic(55, 0, 4'd15);
    test_random_traffic(0, 55, 4'd0);
    test_random_traffic(33, 33, quota_t'($urandom_range(15)));

    wait_drained();
    repeat (4) @(negedge clk);
    if (mismatch_count == 0 && pending_outcomes.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

`default_nettype wire
